// ----- rtl/fir_pkg.sv -----
// fir_pkg: shared constants and control/status structs of the direct-form fir filter
// no dependencies; used by the interfaces, fir_ctrl, fir_dp and fir_filter_direct_form
`default_nettype none

package fir_pkg;

	// request function codes
	localparam int FUNC_BITS = 2;
	localparam logic [FUNC_BITS-1:0] FUNC_FILTER = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_COEF   = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd2;

	localparam int COEF_IDX_BITS = 6;

	// configuration register file
	localparam int TAP_COUNT_BITS = 7;
	localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = 7'd64;
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic REG_TAP_COUNT = 1'b0;

	typedef struct packed {
		logic start_filter;
		logic wr_coef;
		logic clear;
		logic issue;
		logic round;
		logic load_out;
	} fir_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} fir_sts_t;

endpackage

`default_nettype wire

// ----- rtl/fir_if.sv -----
// fir_in_if / fir_out_if: valid-ready channels of the fir filter
// depends on fir_pkg for the function code and coefficient index widths
`default_nettype none

interface fir_in_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                                valid;
	logic                                ready;
	logic [fir_pkg::FUNC_BITS-1:0]       func;
	logic signed [SAMPLE_BITS-1:0]       sample_in;
	logic [fir_pkg::COEF_IDX_BITS-1:0]   coef_index;
	logic signed [SAMPLE_BITS-1:0]       coef_value;

	modport source (output valid, output func, output sample_in, output coef_index,
		output coef_value, input ready);
	modport sink (input valid, input func, input sample_in, input coef_index,
		input coef_value, output ready);
endinterface

interface fir_out_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          saturated;

	modport source (output valid, output sample_out, output saturated, input ready);
	modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

`default_nettype wire

// ----- rtl/fir_filter_direct_form.sv -----
// channel  dir  handshake      payload
// din      in   valid/ready    func, sample_in, coef_index, coef_value
// dout     out  valid/ready    sample_out, saturated
// apb      in   psel/penable   paddr, pwdata -> prdata (tap_count at offset 0)
//
// a filter request walks the tap count (capped at the store depth) between accept and the
// next accept, one tap per cycle through a single multiplier; other requests leave the
// input ready; an unread result holds the next filter result back
// history reads as zero after reset and after a clear through a count of written slots,
// so there is no clearing pass; coefficients must be written before use
//
// fir_filter_direct_form: top level, apb register, controller and datapath
// depends on fir_pkg, fir_if, fir_ctrl and fir_dp
`default_nettype none

module fir_filter_direct_form #(
	parameter int MAX_TAPS    = 64,
	parameter int SAMPLE_BITS = 16,
	parameter int ACC_BITS    = 40
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	fir_in_if.sink                                     din,
	fir_out_if.source                                  dout,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [fir_pkg::APB_ADDR_BITS-1:0]     paddr,
	input  wire logic [fir_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic [fir_pkg::APB_DATA_BITS-1:0]          prdata,
	output logic                                       pready
);

	logic [fir_pkg::TAP_COUNT_BITS-1:0] tap_count_q;
	logic                               reg_wr;
	fir_pkg::fir_cmd_t                  cmd;
	fir_pkg::fir_sts_t                  sts;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == fir_pkg::REG_TAP_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= fir_pkg::TAP_COUNT_RESET;
		end else if (reg_wr) begin
			tap_count_q <= pwdata[fir_pkg::TAP_COUNT_BITS-1:0];
		end
	end

	assign prdata = (paddr[2] == fir_pkg::REG_TAP_COUNT) ?
		fir_pkg::APB_DATA_BITS'(tap_count_q) : '0;

	fir_ctrl #(
		.MAX_TAPS (MAX_TAPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_func   (din.func),
		.in_ready  (din.ready),
		.out_ready (dout.ready),
		.out_valid (dout.valid),
		.tap_count (tap_count_q),
		.sts       (sts),
		.cmd       (cmd)
	);

	fir_dp #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.ACC_BITS    (ACC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.sample_in  (din.sample_in),
		.coef_index (din.coef_index),
		.coef_value (din.coef_value),
		.sample_out (dout.sample_out),
		.saturated  (dout.saturated)
	);

`ifndef SYNTHESIS
	// a filter request keeps the input closed while the taps are walked
	a_filter_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready && din.func == fir_pkg::FUNC_FILTER) |=> !din.ready)
		else $error("input open right after a filter request");

	// coefficient writes and clears never raise a result
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready && din.func != fir_pkg::FUNC_FILTER && !dout.valid)
		|=> !dout.valid)
		else $error("result raised by a non-filter request");

	// a clipped result sits at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.saturated) |->
		(dout.sample_out == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
		 dout.sample_out == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
		else $error("saturated result not at full scale");
`endif

endmodule

`default_nettype wire

// ----- rtl/fir_ctrl.sv -----
// fir_ctrl: request sequencer, tap counter and output valid of the fir filter
// depends on fir_pkg (function codes, command and status structs)
`default_nettype none

module fir_ctrl #(
	parameter int MAX_TAPS = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	input  wire logic [fir_pkg::FUNC_BITS-1:0]         in_func,
	output logic                                       in_ready,
	input  wire logic                                  out_ready,
	output logic                                       out_valid,
	input  wire logic [fir_pkg::TAP_COUNT_BITS-1:0]    tap_count,
	input  wire fir_pkg::fir_sts_t                     sts,
	output fir_pkg::fir_cmd_t                          cmd
);

	localparam int CW = $clog2(MAX_TAPS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_ROUND,
		ST_OUTPUT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] rem_q;
	logic          out_valid_q;
	logic [CW-1:0] taps_eff;
	logic          accept;
	logic          out_free;

	// tap counts above the store depth use the whole store
	assign taps_eff = (32'(tap_count) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(tap_count);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd              = '0;
		cmd.start_filter = accept && (in_func == fir_pkg::FUNC_FILTER);
		cmd.wr_coef      = accept && (in_func == fir_pkg::FUNC_COEF);
		cmd.clear        = accept && (in_func == fir_pkg::FUNC_CLEAR);
		cmd.issue        = (state_q == ST_RUN) && (rem_q != '0);
		cmd.round        = (state_q == ST_ROUND);
		cmd.load_out     = (state_q == ST_OUTPUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start_filter) begin
						rem_q   <= taps_eff;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (rem_q != '0) begin
						rem_q <= rem_q - CW'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// wait for the last product to land in the accumulator
					if (!sts.pipe_busy) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					state_q <= ST_OUTPUT;
				end
				ST_OUTPUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/fir_dp.sv -----
// fir_dp: history and coefficient memories, multiply-accumulate pipe, rounding,
// saturation and output register; depends on fir_pkg (command and status structs)
`default_nettype none

module fir_dp #(
	parameter int MAX_TAPS    = 64,
	parameter int SAMPLE_BITS = 16,
	parameter int ACC_BITS    = 40
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire fir_pkg::fir_cmd_t                   cmd,
	output fir_pkg::fir_sts_t                        sts,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample_in,
	input  wire logic [fir_pkg::COEF_IDX_BITS-1:0]   coef_index,
	input  wire logic signed [SAMPLE_BITS-1:0]       coef_value,
	output logic signed [SAMPLE_BITS-1:0]            sample_out,
	output logic                                     saturated
);

	localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int FW = $clog2(MAX_TAPS + 1);
	localparam int PW = 2 * SAMPLE_BITS;
	localparam int EW = (PW > ACC_BITS) ? PW : ACC_BITS;
	localparam int RW = ((ACC_BITS > SAMPLE_BITS) ? ACC_BITS : SAMPLE_BITS) + 1;
	localparam logic signed [RW-1:0] HALF = RW'(1) << (SAMPLE_BITS - 2);

	logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
	logic [FW-1:0]                 fill_q;

	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW-1:0] k_q;

	logic signed [SAMPLE_BITS-1:0] hist_s1;
	logic signed [SAMPLE_BITS-1:0] coef_s1;
	logic                          hv_s1;
	logic                          v_s1;
	logic signed [PW-1:0]          prod_s2;
	logic                          v_s2;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [RW-1:0]          rnd_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          saturated_q;

	logic                          coef_ok;
	logic signed [SAMPLE_BITS-1:0] hist_op;
	logic signed [EW-1:0]          prod_ext;
	logic signed [RW-1:0]          acc_ext;
	logic [RW-SAMPLE_BITS:0]       rnd_hi;
	logic                          in_range;

	assign coef_ok = (32'(coef_index) < MAX_TAPS);

	// memories: written only between filter passes, read one tap per cycle
	always_ff @(posedge clk) begin
		if (cmd.start_filter) begin
			hist_mem[wp_q] <= sample_in;
		end
		if (cmd.issue) begin
			hist_s1 <= hist_mem[rp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_coef && coef_ok) begin
			coef_mem[AW'(coef_index)] <= coef_value;
		end
		if (cmd.issue) begin
			coef_s1 <= coef_mem[k_q];
		end
	end

	// never-written history slots read as zero: slots fill in order from zero after a
	// clear, so a slot holds a sample exactly when it lies below the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			wp_q   <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.clear) begin
				fill_q <= '0;
				wp_q   <= '0;
			end else if (cmd.start_filter) begin
				if (fill_q != FW'(MAX_TAPS)) begin
					fill_q <= fill_q + FW'(1);
				end
				wp_q <= (wp_q == AW'(MAX_TAPS - 1)) ? '0 : wp_q + AW'(1);
			end
		end
	end

	assign hist_op  = hv_s1 ? hist_s1 : '0;
	assign prod_ext = EW'(prod_s2);
	assign acc_ext  = RW'(acc_q);
	assign rnd_hi   = rnd_q[RW-1:SAMPLE_BITS-1];
	assign in_range = (&rnd_hi) || !(|rnd_hi);

	always_ff @(posedge clk) begin
		if (cmd.start_filter) begin
			rp_q  <= wp_q;
			k_q   <= '0;
			acc_q <= '0;
		end else begin
			if (cmd.issue) begin
				rp_q <= (rp_q == '0) ? AW'(MAX_TAPS - 1) : rp_q - AW'(1);
				k_q  <= k_q + AW'(1);
				hv_s1 <= (FW'(rp_q) < fill_q);
			end
			// accumulator wraps at its own width
			if (v_s2) begin
				acc_q <= acc_q + prod_ext[ACC_BITS-1:0];
			end
		end
		if (v_s1) begin
			prod_s2 <= coef_s1 * hist_op;
		end
		// round half up
		if (cmd.round) begin
			rnd_q <= (acc_ext + HALF) >>> (SAMPLE_BITS - 1);
		end
		if (cmd.load_out) begin
			saturated_q <= !in_range;
			if (in_range) begin
				sample_out_q <= rnd_q[SAMPLE_BITS-1:0];
			end else begin
				sample_out_q <= {rnd_q[RW-1], {(SAMPLE_BITS-1){~rnd_q[RW-1]}}};
			end
		end
	end

	assign sts.pipe_busy = v_s1 || v_s2;
	assign sample_out    = sample_out_q;
	assign saturated     = saturated_q;

endmodule

`default_nettype wire
